[rtl/pfs_pkg.sv]
`timescale 1ns / 1ps

package pfs_pkg;

  // Fixed field widths at the ports
  localparam int IN_BITS    = 16;
  localparam int COUNT_BITS = 8;

  // Defaults for the top-level parameters
  localparam int DEF_VALUE_BITS = 16;
  localparam int DEF_MAX_LENGTH = 128;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Verdict of the front end on an incoming value
  typedef enum logic [1:0] {
    CLS_NOT_PRIME = 2'd0,  // 0, 1 or even above 2
    CLS_PRIME     = 2'd1,  // 2, 3, 5 or 7
    CLS_TEST      = 2'd2   // odd and at least 9: needs trial division
  } cls_t;

  typedef struct packed {
    logic [IN_BITS-1:0] value;
    logic               last;
    cls_t               cls;
  } entry_t;

endpackage

[rtl/pfs_front.sv]
`timescale 1ns / 1ps

module pfs_front #(
  parameter int VALUE_BITS = pfs_pkg::DEF_VALUE_BITS
) (
  input  logic                         in_valid,
  input  logic [pfs_pkg::IN_BITS-1:0]  in_value,
  input  logic                         in_last,
  output logic                         in_stall,
  input  logic                         q_full,
  output logic                         q_push,
  output pfs_pkg::entry_t              q_entry
);
  import pfs_pkg::*;

  localparam int VW = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;

  logic [IN_BITS-1:0] masked;

  assign masked   = IN_BITS'(in_value[VW-1:0]);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.value = masked;
    q_entry.last  = in_last;
    priority if (masked < IN_BITS'(2)) begin
      q_entry.cls = CLS_NOT_PRIME;
    end else if (masked == IN_BITS'(2)) begin
      q_entry.cls = CLS_PRIME;
    end else if (!masked[0]) begin
      q_entry.cls = CLS_NOT_PRIME;
    end else if (masked < IN_BITS'(9)) begin
      q_entry.cls = CLS_PRIME;
    end else begin
      q_entry.cls = CLS_TEST;
    end
  end

endmodule

[rtl/pfs_queue.sv]
`timescale 1ns / 1ps

module pfs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pfs_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output pfs_pkg::entry_t pop_entry
);
  import pfs_pkg::*;

  localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  entry_t            mem [QUEUE_DEPTH];
  logic [PTRW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]   fill_r;
  logic              do_push, do_pop;

  assign full      = (fill_r == CNTW'(QUEUE_DEPTH));
  assign pop_valid = (fill_r != '0);
  assign pop_entry = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  function automatic logic [PTRW-1:0] wrap_inc(logic [PTRW-1:0] p);
    if (p == PTRW'(QUEUE_DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

[rtl/pfs_back.sv]
`timescale 1ns / 1ps

module pfs_back #(
  parameter int VALUE_BITS = pfs_pkg::DEF_VALUE_BITS,
  parameter int MAX_LENGTH = pfs_pkg::DEF_MAX_LENGTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  pfs_pkg::entry_t                q_entry,
  output logic                           q_pop,
  output logic                           out_valid,
  output logic [pfs_pkg::IN_BITS-1:0]    out_prime_value,
  output logic                           out_is_end,
  output logic [pfs_pkg::COUNT_BITS-1:0] out_prime_count,
  input  logic                           out_stall
);
  import pfs_pkg::*;

  localparam int VW    = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
  localparam int CHUNK = 8;                        // dividend bits per cycle
  localparam int STEPS = (VW + CHUNK - 1) / CHUNK;
  localparam int PW    = STEPS * CHUNK;
  localparam int HW    = (VW + 1) / 2;
  localparam int DW    = HW + 1;                   // divisor and remainder
  localparam int SW    = VW + 2;                   // divisor squared
  localparam int CKW   = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CW    = $clog2(MAX_LENGTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PRIME,
    ST_END
  } state_t;

  state_t                  state_r;
  logic [VW-1:0]           val_r;
  logic [IN_BITS-1:0]      val16_r;
  logic                    last_r;
  logic [DW-1:0]           d_r, d_nxt;
  logic [SW-1:0]           sq_r, sq_nxt;
  logic [DW-1:0]           rem_r, rem_nxt;
  logic [CKW-1:0]          chunk_r;
  logic [CW-1:0]           count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [IN_BITS-1:0]      out_prime_value_r;
  logic                    out_is_end_r;
  logic [COUNT_BITS-1:0]   out_prime_count_r;

  logic [PW-1:0]           padded;
  logic [CHUNK-1:0]        chunk;
  logic                    last_chunk;
  logic                    out_free;

  function automatic logic [COUNT_BITS-1:0] low_count(logic [CW-1:0] c);
    logic [CW+COUNT_BITS-1:0] w;
    w = {{COUNT_BITS{1'b0}}, c};
    return w[COUNT_BITS-1:0];
  endfunction

  assign padded     = PW'(val_r);
  assign last_chunk = (chunk_r == CKW'(STEPS - 1));
  assign out_free   = !out_valid_r || !out_stall;
  assign q_pop      = (state_r == ST_IDLE) && q_valid;

  // set on a load, held while stalled, dropped once taken
  assign out_valid_nxt = (out_free && (state_r == ST_PRIME || state_r == ST_END)) ||
                         (out_valid_r && out_stall);

  // most significant chunk first
  always_comb begin
    chunk = '0;
    for (int k = 0; k < STEPS; k++) begin
      if (chunk_r == CKW'(STEPS - 1 - k)) chunk = padded[k*CHUNK +: CHUNK];
    end
  end

  // restoring remainder, one dividend chunk per cycle
  always_comb begin
    logic [DW:0]   t;
    logic [DW-1:0] r;
    r = rem_r;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      t = {r, chunk[i]};
      if (t >= {1'b0, d_r}) t = t - {1'b0, d_r};
      r = t[DW-1:0];
    end
    rem_nxt = r;
  end

  // (d+1)^2 = d^2 + 2d + 1
  assign d_nxt  = d_r + 1'b1;
  assign sq_nxt = sq_r + SW'({d_r, 1'b1});

  assign count_nxt = (count_r < CW'(MAX_LENGTH)) ? count_r + 1'b1 : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            val16_r <= q_entry.value;
            val_r   <= q_entry.value[VW-1:0];
            last_r  <= q_entry.last;
            d_r     <= DW'(3);
            sq_r    <= SW'(9);
            rem_r   <= '0;
            chunk_r <= '0;
            unique case (q_entry.cls)
              CLS_NOT_PRIME: state_r <= q_entry.last ? ST_END : ST_IDLE;
              CLS_PRIME:     state_r <= ST_PRIME;
              CLS_TEST:      state_r <= ST_DIV;
              default:       state_r <= ST_IDLE;
            endcase
          end
        end
        ST_DIV: begin
          if (last_chunk) begin
            rem_r   <= '0;
            chunk_r <= '0;
            d_r     <= d_nxt;
            sq_r    <= sq_nxt;
            if (rem_nxt == '0) begin
              state_r <= last_r ? ST_END : ST_IDLE;
            end else if (sq_nxt > SW'(val_r)) begin
              state_r <= ST_PRIME;
            end
          end else begin
            rem_r   <= rem_nxt;
            chunk_r <= chunk_r + 1'b1;
          end
        end
        ST_PRIME: begin
          if (out_free) begin
            out_prime_value_r <= val16_r;
            out_is_end_r      <= 1'b0;
            out_prime_count_r <= low_count(count_nxt);
            count_r           <= count_nxt;
            state_r           <= last_r ? ST_END : ST_IDLE;
          end
        end
        ST_END: begin
          if (out_free) begin
            out_prime_value_r <= '0;
            out_is_end_r      <= 1'b1;
            out_prime_count_r <= low_count(count_r);
            count_r           <= '0;
            state_r           <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_prime_value = out_prime_value_r;
  assign out_is_end      = out_is_end_r;
  assign out_prime_count = out_prime_count_r;

endmodule

[rtl/prime_filter_stream.sv]
`timescale 1ns / 1ps
// Channel  Ports                                       Direction
// in       in_valid, in_value, in_last / in_stall      request in
// out      out_valid, out_prime_value, out_is_end,
//          out_prime_count / out_stall                 request out
//
// Work: values settled by the front end (0, 1, even, 2..7) need no division in
// the back end. Odd values from 9 up run trial division in the back end, one
// divisor at a time, divisors 3.. while d*d <= value, in an 8-bit-per-cycle
// remainder unit.
// Reset: synchronous, active low; clears the queue, sequencer, count, out_valid.
// Stalls: a two-entry queue keeps taking requests while the back end is busy or
// out_stall holds a finished result in the output register.

module prime_filter_stream #(
  parameter int VALUE_BITS = pfs_pkg::DEF_VALUE_BITS,
  parameter int MAX_LENGTH = pfs_pkg::DEF_MAX_LENGTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [pfs_pkg::IN_BITS-1:0]    in_value,
  input  logic                           in_last,
  output logic                           in_stall,
  output logic                           out_valid,
  output logic [pfs_pkg::IN_BITS-1:0]    out_prime_value,
  output logic                           out_is_end,
  output logic [pfs_pkg::COUNT_BITS-1:0] out_prime_count,
  input  logic                           out_stall
);
  import pfs_pkg::*;

  // front -> queue
  logic   q_push, q_full;
  entry_t push_entry;
  // queue -> back
  logic   q_valid, q_pop;
  entry_t pop_entry;

  // Front end: masks to VALUE_BITS and sorts out trivial cases.
  pfs_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .in_valid (in_valid),
    .in_value (in_value),
    .in_last  (in_last),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  // Decouples acceptance from the long trial-division runs.
  pfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (pop_entry)
  );

  // Back end: trial division, running count, output register.
  pfs_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_entry         (pop_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_prime_value (out_prime_value),
    .out_is_end      (out_is_end),
    .out_prime_count (out_prime_count),
    .out_stall       (out_stall)
  );

endmodule

[sim/prime_filter_stream_tb.sv]
`timescale 1ns / 1ps

module prime_filter_stream_tb;
  import pfs_pkg::*;

  localparam int VALUE_BITS   = DEF_VALUE_BITS;
  localparam int MAX_LENGTH   = DEF_MAX_LENGTH;
  // Requests with the longest trial divisions, 500-odd requests in all, and
  // heavy idling on both sides stay well inside this.
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int HOLD_CYCLES  = 2000;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 600;    // one worst-case division plus results
  localparam int SAT_LENGTH   = 140;    // primes in the saturating array

  // How the two sides idle in the current phase
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic [IN_BITS-1:0] value;
    logic               last;
  } prime_request_t;

  typedef struct {
    logic [IN_BITS-1:0]    prime_value;
    logic                  is_end;
    logic [COUNT_BITS-1:0] prime_count;
  } prime_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic [IN_BITS-1:0]    in_value = '0;
  logic                  in_last = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [IN_BITS-1:0]    out_prime_value;
  logic                  out_is_end;
  logic [COUNT_BITS-1:0] out_prime_count;
  logic                  out_stall = 1'b0;

  prime_request_t pending_requests[$];
  prime_result_t  expected_results[$];

  idle_mode_t  idle_mode = IDLE_NONE;
  logic        hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  // Predictor state: primes counted so far in the current array
  int unsigned array_primes = 0;

  int unsigned requests_taken = 0;
  int unsigned results_seen = 0;
  int unsigned end_results = 0;
  int unsigned saturated_results = 0;
  int unsigned mismatches = 0;

  prime_filter_stream #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_LENGTH(MAX_LENGTH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_value       (in_value),
    .in_last        (in_last),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_prime_value(out_prime_value),
    .out_is_end     (out_is_end),
    .out_prime_count(out_prime_count),
    .out_stall      (out_stall)
  );

  always #1 clk = ~clk;

  // Plain trial division, divisors from 2 while d*d <= n
  function automatic bit is_prime_value(input logic [IN_BITS-1:0] v);
    int unsigned n;
    int unsigned d;
    n = int'(v) & ((1 << VALUE_BITS) - 1);
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Smallest prime at or above start; start must not exceed 65521
  function automatic logic [IN_BITS-1:0] next_prime(input int unsigned start);
    int unsigned p;
    p = start;
    while (!is_prime_value(p[IN_BITS-1:0])) p++;
    return p[IN_BITS-1:0];
  endfunction

  // Works out the results of one accepted request: a prime result if the
  // value is prime, then an end result if it closes the array.
  task automatic predict_primes(input logic [IN_BITS-1:0] value, input logic last);
    prime_result_t r;
    int unsigned   n;
    n = int'(value) & ((1 << VALUE_BITS) - 1);
    if (is_prime_value(value)) begin
      if (array_primes < MAX_LENGTH) array_primes++;
      if (array_primes == MAX_LENGTH) saturated_results++;
      r.prime_value = n[IN_BITS-1:0];
      r.is_end      = 1'b0;
      r.prime_count = array_primes[COUNT_BITS-1:0];
      expected_results.push_back(r);
    end
    if (last) begin
      r.prime_value = '0;
      r.is_end      = 1'b1;
      r.prime_count = array_primes[COUNT_BITS-1:0];
      expected_results.push_back(r);
      array_primes = 0;
    end
  endtask

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 81;
      IDLE_BOTH:   return $urandom_range(99) < 38;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 81;
      IDLE_BOTH:     return $urandom_range(99) < 38;
      default:       return 1'b0;
    endcase
  endfunction

  // Driver: a request is taken at an edge where in_valid is high and in_stall
  // low; the payload is only replaced once the current one has gone.
  always @(posedge clk) begin
    prime_request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_primes(in_value, in_last);
        requests_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && !sender_idles()) begin
          req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_value <= req.value;
          in_last  <= req.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each delivered result against the oldest prediction
  always @(posedge clk) begin
    prime_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_is_end) end_results++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: prime_value %0d is_end %0b prime_count %0d",
                 out_prime_value, out_is_end, out_prime_count);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_prime_value !== want.prime_value) begin
            $error("prime_value: expected %0d, got %0d", want.prime_value, out_prime_value);
            mismatches++;
          end
          if (out_is_end !== want.is_end) begin
            $error("is_end: expected %0b, got %0b", want.is_end, out_is_end);
            mismatches++;
          end
          if (out_prime_count !== want.prime_count) begin
            $error("prime_count: expected %0d, got %0d", want.prime_count, out_prime_count);
            mismatches++;
          end
        end
      end
      out_stall <= (hold_left != 0) || receiver_stalls();
    end
  end

  // Long receiver hold-off, armed by a one-cycle pulse on hold_request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_request) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_request(input logic [IN_BITS-1:0] value, input logic last);
    prime_request_t req;
    req.value = value;
    req.last  = last;
    pending_requests.push_back(req);
  endtask

  // Mix of small values (mostly front-end cases), full-width noise, small and large primes,
  // prime squares (worst case for the d*d bound) and even values.
  function automatic logic [IN_BITS-1:0] pick_value();
    int unsigned  sel;
    logic [IN_BITS-1:0] p;
    sel = $urandom_range(99);
    if (sel < 25) return IN_BITS'($urandom_range(0, 15));
    if (sel < 45) return IN_BITS'($urandom);
    if (sel < 75) return next_prime($urandom_range(2, 2000));
    if (sel < 85) return next_prime($urandom_range(2, 65521));
    if (sel < 95) begin
      p = next_prime($urandom_range(2, 251));
      return p * p;
    end
    return IN_BITS'($urandom) & 16'hFFFE;
  endfunction

  // Well-formed arrays of random length, each closed by a last request
  task automatic queue_random_arrays(input int unsigned target);
    int unsigned n;
    int unsigned len;
    int unsigned k;
    n = 0;
    while (n < target) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (k = 0; k < len; k++) queue_request(pick_value(), k == len - 1);
      n += len;
    end
  endtask

  // Waits until every request has been taken and every result delivered
  task automatic wait_drained();
    @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: front-end verdicts, first trial divisions, boundaries
    queue_request(16'd0, 1'b0);
    queue_request(16'd1, 1'b0);
    queue_request(16'd2, 1'b0);       // smallest prime
    queue_request(16'd3, 1'b0);
    queue_request(16'd4, 1'b0);
    queue_request(16'd5, 1'b0);
    queue_request(16'd7, 1'b0);
    queue_request(16'd8, 1'b0);
    queue_request(16'd9, 1'b0);       // first value needing a divisor
    queue_request(16'd11, 1'b0);
    queue_request(16'd25, 1'b0);
    queue_request(16'd49, 1'b0);
    queue_request(16'd63001, 1'b0);   // 251 squared: divisor reaches the bound
    queue_request(16'd65025, 1'b0);   // 255 squared
    queue_request(16'd65521, 1'b0);   // largest 16-bit prime, longest division
    queue_request(16'hAAAA, 1'b0);
    queue_request(16'h5555, 1'b0);
    queue_request(16'd32768, 1'b0);
    queue_request(16'd65535, 1'b1);   // array ends on a non-prime
    queue_request(16'd4, 1'b1);       // empty array: end result with count 0
    queue_request(16'd0, 1'b1);
    queue_request(16'd65521, 1'b1);   // prime on the last request: two results
    queue_request(16'd2, 1'b1);
    queue_request(16'd1, 1'b1);
    wait_drained();

    // Receiver holds off for a long stretch while the sender keeps offering
    // the saturating array, so the block's queue fills and in_stall rises.
    idle_mode <= IDLE_NONE;
    @(posedge clk);
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    for (int k = 0; k < SAT_LENGTH; k++)
      queue_request(next_prime($urandom_range(2, 400)), k == SAT_LENGTH - 1);
    queue_random_arrays(70);
    wait_drained();

    idle_mode <= IDLE_SENDER;
    queue_random_arrays(85);
    wait_drained();

    idle_mode <= IDLE_RECEIVER;
    queue_random_arrays(85);
    wait_drained();

    idle_mode <= IDLE_BOTH;
    queue_random_arrays(85);
    wait_drained();

    idle_mode <= IDLE_NONE;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end

    $display("covered %0d requests and %0d results, %0d of them array ends",
             requests_taken, results_seen, end_results);
    $display("%0d results at the saturated count, %0d cycles, %0d mismatches",
             saturated_results, cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
